### rtl/tsf_pkg.sv
// types and codes shared by the sun tracker supervisor and its checker
`timescale 1ns / 1ps

package tsf_pkg;

  localparam int unsigned WaitDurationReset = 10000;
  localparam int unsigned MaxRetriesReset   = 10;
  localparam int unsigned RetrySat          = 15;

  typedef enum logic [2:0] {
    MODE_UNINIT = 3'd0,
    MODE_IDLE   = 3'd1,
    MODE_MANUAL = 3'd2,
    MODE_TRACK  = 3'd3,
    MODE_WAIT   = 3'd4,
    MODE_ERROR  = 3'd5
  } mode_e;

  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_STEP     = 4'd1,
    CMD_CONT     = 4'd2,
    CMD_START    = 4'd3,
    CMD_NEXT     = 4'd4,
    CMD_STOP     = 4'd5,
    CMD_STOPPED  = 4'd6,
    CMD_MAXMOVES = 4'd7,
    CMD_TRKERR   = 4'd8,
    CMD_ABORTED  = 4'd9,
    CMD_SUCCESS  = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    MOTOR_NONE = 2'd0,
    MOTOR_STEP = 2'd1,
    MOTOR_CONT = 2'd2,
    MOTOR_STOP = 2'd3
  } motor_cmd_e;

  typedef enum logic [1:0] {
    TRK_NONE  = 2'd0,
    TRK_START = 2'd1,
    TRK_STOP  = 2'd2
  } trk_cmd_e;

  typedef enum logic {
    CFG_WAIT_DURATION = 1'b0,
    CFG_MAX_RETRIES   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]  command;
    logic [1:0]  direction;
    logic [47:0] time_ms;
  } in_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       panel;
    logic [1:0] motor_cmd;
    logic [1:0] motor_dir;
    logic [1:0] tracker_cmd;
  } out_t;

endpackage

### rtl/tracker_supervisor_fsm_unit.sv
// sun tracker supervisor: mode state machine with registered input and result
`timescale 1ns / 1ps

//  channel   direction  signals                          transfer when
//  in        input      in_valid_i, in_stall_o, in_data_i   valid && !stall
//  out       output     out_valid_o, out_stall_i, out_data_o valid && !stall
//  cfg       input      cfg_we_i, cfg_idx_i, cfg_wdata_i      cfg_we_i
//
// one event per cycle sustained while out is not stalled; a result reaches out through the
// input register, then the result register after the decision logic
// the decision path is one 48-bit subtract and compare plus the mode decode
// reset puts the mode in uninitialized, panel A, retry count and wait start zero
// a stall on out holds the result and backs up into in_stall_o through one stage

module tracker_supervisor_fsm_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tsf_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tsf_pkg::out_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [31:0]    cfg_wdata_i
);
  import tsf_pkg::*;

  in_t         in_q;
  logic        in_valid_q;
  out_t        out_q, out_d;
  logic        out_valid_q;
  logic        out_ready;
  logic        fire;
  logic        in_load;

  logic [31:0] wait_dur_q;
  logic [3:0]  max_retries_q;

  mode_e       mode_q, mode_d;
  logic        panel_q, panel_d;
  logic [3:0]  retry_q, retry_d;
  logic [47:0] wait_start_q, wait_start_d;

  logic [47:0] elapsed;
  logic        expired;
  logic        over;
  logic [3:0]  cmd;
  motor_cmd_e  mcmd;
  logic [1:0]  mdir;
  trk_cmd_e    tcmd;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign fire      = in_valid_q && out_ready;
  assign in_load   = in_valid_i && !in_stall_o;
  assign in_stall_o = in_valid_q && !out_ready;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_dur_q    <= 32'(WaitDurationReset);
      max_retries_q <= 4'(MaxRetriesReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WAIT_DURATION: wait_dur_q    <= cfg_wdata_i;
        CFG_MAX_RETRIES:   max_retries_q <= cfg_wdata_i[3:0];
        default:           ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= in_data_i;
    end
  end

  assign cmd     = in_q.command;
  assign elapsed = in_q.time_ms - wait_start_q;
  assign expired = elapsed > {16'd0, wait_dur_q};
  assign over    = retry_q > max_retries_q;

  // next mode
  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      MODE_UNINIT: mode_d = MODE_IDLE;
      MODE_IDLE, MODE_MANUAL: begin
        if (cmd inside {CMD_STEP, CMD_CONT}) begin
          mode_d = MODE_MANUAL;
        end else if (cmd == CMD_START) begin
          mode_d = MODE_TRACK;
        end else if (mode_q == MODE_MANUAL && cmd == CMD_STOPPED) begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_TRACK: begin
        if (cmd == CMD_MAXMOVES || (cmd == CMD_TRKERR && over)) begin
          mode_d = MODE_ERROR;
        end else if (cmd == CMD_ABORTED) begin
          mode_d = MODE_IDLE;
        end else if (cmd == CMD_SUCCESS) begin
          mode_d = MODE_WAIT;
        end
      end
      MODE_WAIT: begin
        if (cmd == CMD_STOP) begin
          mode_d = MODE_IDLE;
        end else if (expired) begin
          mode_d = MODE_TRACK;
        end
      end
      MODE_ERROR: begin
        if (cmd == CMD_STOP) begin
          mode_d = MODE_IDLE;
        end
      end
      default: mode_d = mode_q;
    endcase
  end

  // commands and side state
  always_comb begin
    mcmd         = MOTOR_NONE;
    mdir         = 2'd0;
    tcmd         = TRK_NONE;
    panel_d      = panel_q;
    retry_d      = retry_q;
    wait_start_d = wait_start_q;
    case (mode_q)
      MODE_IDLE, MODE_MANUAL: begin
        if (cmd == CMD_START) begin
          retry_d = 4'd0;
          tcmd    = TRK_START;
        end else if (cmd == CMD_STEP) begin
          mcmd = MOTOR_STEP;
          mdir = in_q.direction;
        end else if (cmd == CMD_CONT) begin
          mcmd = MOTOR_CONT;
          mdir = in_q.direction;
        end else if (cmd == CMD_NEXT) begin
          panel_d = !panel_q;
          if (mode_q == MODE_MANUAL) begin
            mcmd = MOTOR_STOP;
          end
        end else if (mode_q == MODE_MANUAL && cmd == CMD_STOP) begin
          mcmd = MOTOR_STOP;
        end
      end
      MODE_TRACK: begin
        if (cmd == CMD_STOP) begin
          tcmd = TRK_STOP;
        end else if (cmd == CMD_TRKERR) begin
          if (retry_q != 4'(RetrySat)) begin
            retry_d = retry_q + 4'd1;
          end
          if (!over) begin
            tcmd = TRK_START;
          end
        end else if (cmd == CMD_SUCCESS) begin
          wait_start_d = in_q.time_ms;
          panel_d      = !panel_q;
        end
      end
      MODE_WAIT: begin
        if (cmd != CMD_STOP && expired) begin
          retry_d = 4'd0;
          tcmd    = TRK_START;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_UNINIT;
      panel_q      <= 1'b0;
      retry_q      <= 4'd0;
      wait_start_q <= 48'd0;
    end else if (fire) begin
      mode_q       <= mode_d;
      panel_q      <= panel_d;
      retry_q      <= retry_d;
      wait_start_q <= wait_start_d;
    end
  end

  always_comb begin
    out_d.mode        = mode_d;
    out_d.panel       = panel_d;
    out_d.motor_cmd   = mcmd;
    out_d.motor_dir   = mdir;
    out_d.tracker_cmd = tcmd;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/tsf_checker.sv
// port-level checks for the sun tracker supervisor, bound to the top level
`timescale 1ns / 1ps

module tsf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input tsf_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input tsf_pkg::out_t out_data_o
);
  import tsf_pkg::*;

  // a stalled input transfer keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // motor commands only come with manual mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.motor_cmd != MOTOR_NONE |-> out_data_o.mode == MODE_MANUAL)
    else $error("motor command outside manual mode");

  // tracker commands only come with tracking mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tracker_cmd != TRK_NONE |-> out_data_o.mode == MODE_TRACK)
    else $error("tracker command outside tracking mode");

  // direction is zero unless a move is commanded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.motor_dir != 2'd0 |->
      out_data_o.motor_cmd == MOTOR_STEP || out_data_o.motor_cmd == MOTOR_CONT)
    else $error("direction without move command");

endmodule

bind tracker_supervisor_fsm_unit tsf_checker u_tsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### test/tracker_supervisor_fsm_unit_tb.sv
// self-checking testbench for the sun tracker supervisor state machine
`timescale 1ns / 1ps

module tracker_supervisor_fsm_unit_tb;
  import tsf_pkg::*;

  localparam int unsigned CycleLimit     = 300000;
  localparam int unsigned HoldCycles     = 100;
  localparam logic [3:0]  CmdUnknownTop  = 4'd15;
  localparam logic [47:0] TimeTop        = 48'hFFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;
  logic [31:0] cfg_wdata;

  // mirror of the supervisor state and settings
  mode_e       mode_q;
  logic        panel_q;
  logic [3:0]  retries_q;
  logic [47:0] wait_start_q;
  logic [31:0] wait_dur_q;
  logic [3:0]  max_retry_q;

  out_t        status_due_q[$];
  logic [47:0] now_ms;
  bit          idle_on;
  bit          hold_req;
  int unsigned mismatches;
  int unsigned cycle_count;

  tracker_supervisor_fsm_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // next status of the supervisor for one event, advancing the mirrored state
  function automatic out_t step_supervisor(input in_t ev);
    out_t        res;
    mode_e       next_mode;
    logic [47:0] elapsed;
    logic        over;
    res = '0;
    next_mode = mode_q;
    elapsed = ev.time_ms - wait_start_q;
    case (mode_q)
      MODE_UNINIT: next_mode = MODE_IDLE;
      MODE_IDLE, MODE_MANUAL: begin
        if (ev.command == CMD_START) begin
          retries_q = '0;
          res.tracker_cmd = TRK_START;
          next_mode = MODE_TRACK;
        end else if (ev.command == CMD_STEP || ev.command == CMD_CONT) begin
          res.motor_cmd = (ev.command == CMD_STEP) ? MOTOR_STEP : MOTOR_CONT;
          res.motor_dir = ev.direction;
          next_mode = MODE_MANUAL;
        end else if (mode_q == MODE_IDLE) begin
          if (ev.command == CMD_NEXT) panel_q = ~panel_q;
        end else if (ev.command == CMD_STOP) begin
          res.motor_cmd = MOTOR_STOP;
        end else if (ev.command == CMD_NEXT) begin
          panel_q = ~panel_q;
          res.motor_cmd = MOTOR_STOP;
        end else if (ev.command == CMD_STOPPED) begin
          next_mode = MODE_IDLE;
        end
      end
      MODE_TRACK: begin
        case (ev.command)
          CMD_STOP:     res.tracker_cmd = TRK_STOP;
          CMD_MAXMOVES: next_mode = MODE_ERROR;
          CMD_TRKERR: begin
            over = retries_q > max_retry_q;
            if (retries_q < RetrySat) retries_q = retries_q + 4'd1;
            if (over) next_mode = MODE_ERROR;
            else res.tracker_cmd = TRK_START;
          end
          CMD_ABORTED:  next_mode = MODE_IDLE;
          CMD_SUCCESS: begin
            wait_start_q = ev.time_ms;
            panel_q = ~panel_q;
            next_mode = MODE_WAIT;
          end
          default: ;
        endcase
      end
      MODE_WAIT: begin
        if (ev.command == CMD_STOP) begin
          next_mode = MODE_IDLE;
        end else if (elapsed > {16'd0, wait_dur_q}) begin
          retries_q = '0;
          res.tracker_cmd = TRK_START;
          next_mode = MODE_TRACK;
        end
      end
      MODE_ERROR: if (ev.command == CMD_STOP) next_mode = MODE_IDLE;
      default: ;
    endcase
    mode_q = next_mode;
    res.mode = next_mode;
    res.panel = panel_q;
    return res;
  endfunction

  function automatic void flag_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endfunction

  // time stamps: mostly small steps, some wild jumps, and hits around the wait boundary
  function automatic logic [47:0] pick_time();
    case ($urandom_range(0, 9))
      0: now_ms = {16'($urandom), 32'($urandom)};
      1, 2, 3: now_ms = now_ms + 48'($urandom_range(0, 3000));
      default: begin
        if (mode_q == MODE_WAIT)
          now_ms = wait_start_q + {16'd0, wait_dur_q} + 48'($urandom_range(0, 2)) - 48'd1;
        else
          now_ms = now_ms + 48'($urandom_range(0, 50));
      end
    endcase
    return now_ms;
  endfunction

  // mostly events that make sense in the current mode, some noise
  function automatic in_t random_event(input int unsigned trkerr_pct);
    in_t ev;
    ev.direction = 2'($urandom);
    ev.time_ms = pick_time();
    if ($urandom_range(0, 99) < 12) begin
      ev.command = 4'($urandom);
    end else begin
      case (mode_q)
        MODE_IDLE: begin
          case ($urandom_range(0, 4))
            0: ev.command = CMD_STEP;
            1: ev.command = CMD_CONT;
            2: ev.command = CMD_START;
            3: ev.command = CMD_NEXT;
            default: ev.command = CMD_NONE;
          endcase
        end
        MODE_MANUAL: begin
          case ($urandom_range(0, 5))
            0: ev.command = CMD_STEP;
            1: ev.command = CMD_CONT;
            2: ev.command = CMD_STOP;
            3: ev.command = CMD_NEXT;
            4: ev.command = CMD_STOPPED;
            default: ev.command = CMD_START;
          endcase
        end
        MODE_TRACK: begin
          if ($urandom_range(0, 99) < trkerr_pct) begin
            ev.command = CMD_TRKERR;
          end else begin
            case ($urandom_range(0, 4))
              0: ev.command = CMD_STOP;
              1: ev.command = CMD_MAXMOVES;
              2: ev.command = CMD_ABORTED;
              default: ev.command = CMD_SUCCESS;
            endcase
          end
        end
        MODE_WAIT: begin
          case ($urandom_range(0, 19))
            0: ev.command = CMD_STOP;
            1, 2: ev.command = 4'($urandom);
            default: ev.command = CMD_NONE;
          endcase
        end
        MODE_ERROR: ev.command = ($urandom_range(0, 1) == 0) ? CMD_STOP : 4'($urandom);
        default: ev.command = 4'($urandom);
      endcase
    end
    return ev;
  endfunction

  // called at a rising edge; returns at the edge where the transfer happened
  task automatic send_event(input in_t ev);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
    status_due_q.push_back(step_supervisor(ev));
  endtask

  task automatic send_cmd(input logic [3:0] cmd, input logic [1:0] dir,
                          input logic [47:0] stamp);
    in_t ev;
    ev.command = cmd;
    ev.direction = dir;
    ev.time_ms = stamp;
    send_event(ev);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] dur, input logic [3:0] retries);
    wait_all_results();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_WAIT_DURATION;
    cfg_wdata <= dur;
    @(posedge clk);
    cfg_idx   <= CFG_MAX_RETRIES;
    cfg_wdata <= {28'd0, retries};
    @(posedge clk);
    cfg_we    <= 1'b0;
    wait_dur_q = dur;
    max_retry_q = retries;
  endtask

  // walk every mode with the reset settings, including the wait boundary across a wrap
  task automatic test_mode_walk();
    send_cmd(CMD_SUCCESS, 2'd3, 48'd0);
    send_cmd(CMD_NEXT, 2'd0, now_ms);
    send_cmd(CMD_STEP, 2'd2, now_ms);
    send_cmd(CMD_CONT, 2'd3, now_ms);
    send_cmd(CMD_STOP, 2'd1, now_ms);
    send_cmd(CMD_NEXT, 2'd2, now_ms);
    send_cmd(CmdUnknownTop, 2'd3, TimeTop);
    send_cmd(CMD_STOPPED, 2'd0, now_ms);
    send_cmd(CMD_MAXMOVES, 2'd1, now_ms);
    send_cmd(CMD_START, 2'd0, now_ms);
    send_cmd(CMD_STOP, 2'd0, now_ms);
    send_cmd(CMD_TRKERR, 2'd0, now_ms);
    send_cmd(CMD_NONE, 2'd0, now_ms);
    send_cmd(CMD_ABORTED, 2'd0, now_ms);
    send_cmd(CMD_STEP, 2'd1, now_ms);
    send_cmd(CMD_START, 2'd2, now_ms);
    send_cmd(CMD_SUCCESS, 2'd0, TimeTop);
    // elapsed equal to the duration keeps waiting, one more starts tracking
    send_cmd(CMD_NONE, 2'd0, TimeTop + 48'(WaitDurationReset));
    send_cmd(CMD_NONE, 2'd0, TimeTop + 48'(WaitDurationReset) + 48'd1);
    send_cmd(CMD_MAXMOVES, 2'd0, now_ms);
    send_cmd(CMD_START, 2'd0, now_ms);
    send_cmd(CMD_STOP, 2'd0, now_ms);
  endtask

  task automatic test_retry_exhaustion();
    configure(WaitDurationReset, 4'd0);
    send_cmd(CMD_START, 2'd0, now_ms);
    send_cmd(CMD_TRKERR, 2'd0, now_ms);
    send_cmd(CMD_TRKERR, 2'd0, now_ms);
    send_cmd(CMD_STOP, 2'd0, now_ms);
  endtask

  task automatic test_random_traffic(input logic [31:0] dur, input logic [3:0] retries,
                                     input int unsigned count, input int unsigned trkerr_pct);
    configure(dur, retries);
    repeat (count) send_event(random_event(trkerr_pct));
  endtask

  // long hold on the result side while events keep coming, so the input backs up
  task automatic test_output_backpressure();
    configure(32'($urandom_range(1, 5000)), 4'($urandom_range(0, 14)));
    hold_req = 1'b1;
    repeat (40) send_event(random_event(50));
  endtask

  initial begin : drive_out_stall
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_status
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_due_q.size() == 0) begin
        flag_mismatch("result with none pending, mode", 0, out_data.mode);
      end else begin
        want = status_due_q.pop_front();
        if (out_data.mode != want.mode) flag_mismatch("mode", want.mode, out_data.mode);
        if (out_data.panel != want.panel) flag_mismatch("panel", want.panel, out_data.panel);
        if (out_data.motor_cmd != want.motor_cmd)
          flag_mismatch("motor_cmd", want.motor_cmd, out_data.motor_cmd);
        if (out_data.motor_dir != want.motor_dir)
          flag_mismatch("motor_dir", want.motor_dir, out_data.motor_dir);
        if (out_data.tracker_cmd != want.tracker_cmd)
          flag_mismatch("tracker_cmd", want.tracker_cmd, out_data.tracker_cmd);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_WAIT_DURATION;
    cfg_wdata <= '0;
    mode_q       = MODE_UNINIT;
    panel_q      = 1'b0;
    retries_q    = '0;
    wait_start_q = '0;
    wait_dur_q   = WaitDurationReset;
    max_retry_q  = 4'(MaxRetriesReset);
    now_ms       = '0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    mismatches   = 0;
    cycle_count  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_mode_walk();
    test_retry_exhaustion();
    test_random_traffic(32'd0, 4'd0, 300, 40);
    // heavy retry storms so the count reaches saturation
    test_random_traffic(32'hFFFF_FFFF, 4'd14, 300, 92);
    test_output_backpressure();
    test_random_traffic(32'($urandom_range(1, 5000)), 4'($urandom_range(0, 14)), 250, 50);
    test_random_traffic(32'($urandom), 4'($urandom_range(0, 14)), 250, 50);
    idle_on = 1'b0;
    test_random_traffic(WaitDurationReset, 4'(MaxRetriesReset), 250, 60);

    wait_all_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/tsf_pkg.sv
rtl/tracker_supervisor_fsm_unit.sv
rtl/tsf_checker.sv
test/tracker_supervisor_fsm_unit_tb.sv
